FILE: rtl/audio_block_peak_rms_meter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the peak / rms meter
// Concurrent checks that vanish when synthesising.
// ----------------------------------------------------------------------------
`ifndef AUDIO_BLOCK_PEAK_RMS_METER_ASSERT_SVH
`define AUDIO_BLOCK_PEAK_RMS_METER_ASSERT_SVH
`ifndef SYNTHESIS
// check that a condition implies another in the same cycle
`define ABPRM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("meter check failed");
// check that a condition implies another in the next cycle
`define ABPRM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("meter check failed");
`else
`define ABPRM_ASSERT_SAME(lbl, ante, cons)
`define ABPRM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/abprm_pkg.sv
// ----------------------------------------------------------------------------
// abprm_pkg
// Types, constants and helpers shared by the peak / rms meter.
// ----------------------------------------------------------------------------
package abprm_pkg;

    localparam int PLANES         = 4;
    localparam int NIN            = 4;
    localparam int BLOCK_FRAMES   = 64;
    localparam int FULLSCALE_BITS = 23;
    localparam int SMP_W          = 28;
    localparam int OUT_W          = 24;
    localparam int SQ_W           = 2 * SMP_W;
    localparam int SUM_W          = 60;
    localparam int ROOT_W         = SUM_W / 2;
    localparam int LVL_W          = 16;
    localparam int DECAY_W        = 16;
    localparam int PROD_W         = SMP_W + DECAY_W;
    localparam int CLIP_W         = 16;
    localparam int CNT_W          = $clog2(BLOCK_FRAMES + 1);
    localparam int PL_W           = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int IT_W           = $clog2(SUM_W);
    localparam int LANE_CNT_W     = $clog2(PLANES + 1);

    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd58982;
    localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};
    localparam logic [LVL_W-1:0]   LVL_MAX     = {LVL_W{1'b1}};

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_METER = 1'b1;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample_0;
        logic signed [SMP_W-1:0] sample_1;
        logic signed [SMP_W-1:0] sample_2;
        logic signed [SMP_W-1:0] sample_3;
        logic                    end_of_block;
    } t_in_item;

    typedef struct packed {
        logic                    kind;
        logic [1:0]              plane;
        logic signed [OUT_W-1:0] out_0;
        logic signed [OUT_W-1:0] out_1;
        logic signed [OUT_W-1:0] out_2;
        logic signed [OUT_W-1:0] out_3;
        logic [LVL_W-1:0]        peak_level;
        logic [LVL_W-1:0]        rms_level;
        logic [CLIP_W-1:0]       clip_count;
        logic                    last;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic square;
        logic accum;
        logic start;
    } t_lane_ctrl;

    typedef struct packed {
        logic             busy;
        logic [LVL_W-1:0] peak_level;
        logic [LVL_W-1:0] rms_level;
    } t_lane_stat;

    typedef enum logic [2:0] {
        S_IDLE, S_SQR, S_ACC, S_FRAME, S_CALC, S_WAIT, S_METER
    } t_state;

    typedef enum logic [2:0] {
        L_IDLE, L_MUL, L_HOLD, L_DIV, L_SQRT, L_LVL
    } t_lane_st;

    // scale a magnitude to a 16-bit meter, full scale and above read as maximum
    function automatic logic [LVL_W-1:0] to_level(input logic [ROOT_W-1:0] v);
        logic [FULLSCALE_BITS+LVL_W-1:0] prod;
        prod = v[FULLSCALE_BITS-1:0] * (FULLSCALE_BITS + LVL_W)'(LVL_MAX);
        if (v >= ROOT_W'(2 ** FULLSCALE_BITS)) begin
            return LVL_MAX;
        end
        return prod[FULLSCALE_BITS+LVL_W-1:FULLSCALE_BITS];
    endfunction

endpackage

FILE: rtl/abprm_lane.sv
// ----------------------------------------------------------------------------
// abprm_lane
// One plane: clamp, square and peak accumulation per frame, then peak hold
// decay, mean-square division and square root at block close.
// ----------------------------------------------------------------------------
module abprm_lane (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  abprm_pkg::t_lane_ctrl             i_ctrl,
    input  logic signed [abprm_pkg::SMP_W-1:0] i_sample,
    input  logic [abprm_pkg::CNT_W-1:0]       i_frames,
    input  logic [abprm_pkg::DECAY_W-1:0]     i_decay,
    output logic signed [abprm_pkg::OUT_W-1:0] o_out,
    output logic                              o_clip,
    output abprm_pkg::t_lane_stat             o_stat
);
    import abprm_pkg::*;

    localparam logic signed [SMP_W-1:0] POS_LIM = SMP_W'(2 ** FULLSCALE_BITS - 1);
    localparam logic signed [SMP_W-1:0] NEG_LIM = -SMP_W'(2 ** FULLSCALE_BITS);
    localparam int RW = ROOT_W + 2;

    t_lane_st r_st, n_st;

    logic signed [SMP_W-1:0] r_x;
    logic [SMP_W-1:0]        r_mag;
    logic [SQ_W-1:0]         r_sq;
    logic signed [OUT_W-1:0] r_y, n_y;
    logic                    r_clip, n_clip;
    logic [SMP_W-1:0]        r_peak, r_hold, r_bp;
    logic [SUM_W-1:0]        r_sum, r_dvd;
    logic [PROD_W-1:0]       r_prod;
    logic [CNT_W-1:0]        r_rem;
    logic [RW-1:0]           r_srem;
    logic [ROOT_W-1:0]       r_root;
    logic [IT_W-1:0]         r_it;
    logic [LVL_W-1:0]        r_pk_lvl, r_rms_lvl;
    logic [SMP_W-1:0]        mag;
    logic [SUM_W:0]          sum_add;
    logic [CNT_W:0]          div_try;
    logic [RW+1:0]           sq_cand, sq_trial;
    logic                    it_end;

    // magnitude and hard clamp of the held sample
    always_comb begin
        mag    = r_x[SMP_W-1] ? SMP_W'(-r_x) : SMP_W'(r_x);
        n_y    = OUT_W'(r_x);
        n_clip = 1'b0;
        if (r_x >= POS_LIM + SMP_W'(1)) begin
            n_y    = OUT_W'(POS_LIM);
            n_clip = 1'b1;
        end else if (r_x <= NEG_LIM) begin
            n_y    = OUT_W'(NEG_LIM);
            n_clip = 1'b1;
        end
    end

    assign sum_add  = {1'b0, r_sum} + (SUM_W + 1)'(r_sq);
    assign div_try  = {r_rem, r_dvd[SUM_W-1]};
    assign sq_cand  = {r_srem, r_dvd[SUM_W-1 -: 2]};
    assign sq_trial = (RW + 2)'({r_root, 2'b01});

    // next state of the close sequencer
    always_comb begin
        n_st   = r_st;
        it_end = 1'b0;
        case (r_st)
            L_IDLE: begin
                if (i_ctrl.start) n_st = L_MUL;
            end
            L_MUL:  n_st = L_HOLD;
            L_HOLD: n_st = L_DIV;
            L_DIV: begin
                it_end = (r_it == IT_W'(SUM_W - 1));
                if (it_end) n_st = L_SQRT;
            end
            L_SQRT: begin
                it_end = (r_it == IT_W'(ROOT_W - 1));
                if (it_end) n_st = L_LVL;
            end
            L_LVL:  n_st = L_IDLE;
            default: n_st = L_IDLE;
        endcase
    end

    // status towards the merge stage
    always_comb begin
        o_stat.busy       = (r_st != L_IDLE);
        o_stat.peak_level = r_pk_lvl;
        o_stat.rms_level  = r_rms_lvl;
    end

    assign o_out  = r_y;
    assign o_clip = r_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= L_IDLE;
            r_peak <= '0;
            r_hold <= '0;
            r_sum  <= '0;
        end else begin
            r_st <= n_st;
            // capture the request's sample
            if (i_ctrl.load) r_x <= i_sample;
            // square and clamp
            if (i_ctrl.square) begin
                r_mag  <= mag;
                r_sq   <= mag * mag;
                r_y    <= n_y;
                r_clip <= n_clip;
            end
            // accumulate peak and saturating sum of squares
            if (i_ctrl.accum) begin
                if (r_mag > r_peak) r_peak <= r_mag;
                r_sum <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
            end
            case (r_st)
                L_IDLE: begin
                    if (i_ctrl.start) begin
                        r_bp   <= r_peak;
                        r_dvd  <= r_sum;
                        r_peak <= '0;
                        r_sum  <= '0;
                    end
                end
                L_MUL: begin
                    r_prod <= r_hold * i_decay;
                    r_rem  <= '0;
                    r_it   <= '0;
                end
                L_HOLD: begin
                    r_hold <= (r_bp > r_prod[PROD_W-1:DECAY_W]) ? r_bp
                                                              : r_prod[PROD_W-1:DECAY_W];
                end
                L_DIV: begin
                    // one quotient bit per cycle
                    if (div_try >= {1'b0, i_frames}) begin
                        r_rem <= CNT_W'(div_try - {1'b0, i_frames});
                        r_dvd <= {r_dvd[SUM_W-2:0], 1'b1};
                    end else begin
                        r_rem <= CNT_W'(div_try);
                        r_dvd <= {r_dvd[SUM_W-2:0], 1'b0};
                    end
                    r_it   <= it_end ? '0 : r_it + IT_W'(1);
                    r_srem <= '0;
                    r_root <= '0;
                end
                L_SQRT: begin
                    // one root bit per cycle
                    if (sq_cand >= sq_trial) begin
                        r_srem <= RW'(sq_cand - sq_trial);
                        r_root <= {r_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_srem <= RW'(sq_cand);
                        r_root <= {r_root[ROOT_W-2:0], 1'b0};
                    end
                    r_dvd <= {r_dvd[SUM_W-3:0], 2'b00};
                    r_it  <= r_it + IT_W'(1);
                end
                L_LVL: begin
                    r_pk_lvl  <= to_level(ROOT_W'(r_hold));
                    r_rms_lvl <= to_level(r_root);
                end
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/audio_block_peak_rms_meter.sv
// ----------------------------------------------------------------------------
// audio_block_peak_rms_meter
// Clamps four-plane frames to 24 bits and reports block peak hold and rms.
// ----------------------------------------------------------------------------
// One frame is taken at a time: a frame request passes through capture, square,
// accumulate and result, and the next is accepted only once the result has
// been taken by the output side. At block close each plane lane runs its own
// decay multiply, a bit-serial divide by the frame count and a bit-serial
// square root, and a closing frame holds the input until the four meter
// reports, one per plane, have been taken.
module audio_block_peak_rms_meter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  abprm_pkg::t_in_item            i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output abprm_pkg::t_out_item           o_out_data,
    input  logic                           i_cfg_we,
    input  logic [abprm_pkg::DECAY_W-1:0]  i_cfg_data
);
    import abprm_pkg::*;
`include "audio_block_peak_rms_meter_assert.svh"

    t_state r_st, n_st;

    logic [DECAY_W-1:0]      r_decay;
    logic [CNT_W-1:0]        r_fc, r_frames, fc_inc;
    logic                    r_eob, r_close, close;
    logic [CLIP_W-1:0]       r_clips, clips_new;
    logic [PL_W-1:0]         r_pl;
    logic                    r_valid;
    t_out_item               r_out, frame_res, meter_res;
    t_lane_ctrl              ctrl;
    t_lane_stat              stat [PLANES];
    logic signed [OUT_W-1:0] lane_out [PLANES];
    logic signed [SMP_W-1:0] lane_in [PLANES];
    logic [PLANES-1:0]       lane_clip, lane_busy;
    logic signed [OUT_W-1:0] outs [4];
    logic                    accept, taken, all_idle, last_pl;

    assign accept = i_in_valid && o_in_ready;
    assign taken  = r_valid && i_out_ready;

    // spread the request's samples over the lanes
    always_comb begin
        for (int p = 0; p < PLANES; p++) begin
            case (p)
                0: lane_in[p] = i_in_data.sample_0;
                1: lane_in[p] = i_in_data.sample_1;
                2: lane_in[p] = i_in_data.sample_2;
                3: lane_in[p] = i_in_data.sample_3;
                default: lane_in[p] = '0;
            endcase
        end
    end

    for (genvar g = 0; g < PLANES; g++) begin : g_lane
        abprm_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (ctrl),
            .i_sample (lane_in[g]),
            .i_frames (r_frames),
            .i_decay  (r_decay),
            .o_out    (lane_out[g]),
            .o_clip   (lane_clip[g]),
            .o_stat   (stat[g])
        );
        assign lane_busy[g] = stat[g].busy;
    end

    // merge lane findings: clip total, close decision, result items
    always_comb begin
        for (int p = 0; p < 4; p++) begin
            outs[p] = (p < PLANES && p < NIN) ? lane_out[p] : '0;
        end
        clips_new = r_clips + CLIP_W'($countones(lane_clip));
        fc_inc    = r_fc + CNT_W'(1);
        close     = r_eob || (fc_inc >= CNT_W'(BLOCK_FRAMES));
        all_idle  = (lane_busy == '0);
        last_pl   = (r_pl == PL_W'(PLANES - 1));

        frame_res            = '0;
        frame_res.kind       = KIND_FRAME;
        frame_res.out_0      = outs[0];
        frame_res.out_1      = outs[1];
        frame_res.out_2      = outs[2];
        frame_res.out_3      = outs[3];
        frame_res.clip_count = clips_new;
        frame_res.last       = !close;

        meter_res            = '0;
        meter_res.kind       = KIND_METER;
        meter_res.plane      = 2'(r_pl);
        meter_res.peak_level = stat[r_pl].peak_level;
        meter_res.rms_level  = stat[r_pl].rms_level;
        meter_res.clip_count = r_clips;
        meter_res.last       = last_pl;
    end

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:  if (accept) n_st = S_SQR;
            S_SQR:   n_st = S_ACC;
            S_ACC:   n_st = S_FRAME;
            S_FRAME: if (taken) n_st = r_close ? S_CALC : S_IDLE;
            S_CALC:  n_st = S_WAIT;
            S_WAIT:  if (all_idle) n_st = S_METER;
            S_METER: if (taken && last_pl) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready   = (r_st == S_IDLE);
        ctrl.load    = accept;
        ctrl.square  = (r_st == S_SQR);
        ctrl.accum   = (r_st == S_ACC);
        ctrl.start   = (r_st == S_CALC);
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_decay <= DECAY_RESET;
            r_fc    <= '0;
            r_clips <= '0;
            r_valid <= 1'b0;
            r_close <= 1'b0;
            r_pl    <= '0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) r_decay <= i_cfg_data;
            if (accept) r_eob <= i_in_data.end_of_block;
            // close the frame and load its result
            if (r_st == S_ACC) begin
                r_clips  <= clips_new;
                r_frames <= fc_inc;
                r_fc     <= close ? '0 : fc_inc;
                r_close  <= close;
                r_out    <= frame_res;
                r_valid  <= 1'b1;
            end
            if (r_st == S_FRAME && taken) r_valid <= 1'b0;
            // present the meter reports in plane order
            if (r_st == S_WAIT && all_idle) begin
                r_pl <= '0;
            end
            if (r_st == S_METER && !r_valid) begin
                r_out   <= meter_res;
                r_valid <= 1'b1;
            end
            if (r_st == S_METER && taken) begin
                r_valid <= 1'b0;
                r_pl    <= last_pl ? '0 : r_pl + PL_W'(1);
            end
        end
    end

    `ABPRM_ASSERT_SAME(a_ready_idle, o_in_ready, !o_out_valid)
    `ABPRM_ASSERT_SAME(a_fc_range, 1'b1, r_fc < CNT_W'(BLOCK_FRAMES))
    `ABPRM_ASSERT_SAME(a_last_plane, o_out_valid && o_out_data.kind == KIND_METER && o_out_data.last, o_out_data.plane == 2'(PLANES - 1))
    `ABPRM_ASSERT_NEXT(a_calc_busy, r_st == S_CALC, lane_busy != '0)

endmodule

FILE: dv/audio_block_peak_rms_meter_test.sv
// ----------------------------------------------------------------------------
// Peak / rms meter testbench
// Drives four-plane frames through the meter with random gaps on both sides,
// predicts every frame result and meter report, and checks each one in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module audio_block_peak_rms_meter_test;
    import abprm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int FS = 1 << FULLSCALE_BITS;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_ready;
    t_in_item        i_in_data;
    logic            o_out_valid;
    logic            i_out_ready;
    t_out_item       o_out_data;
    logic            i_cfg_we;
    logic [DECAY_W-1:0] i_cfg_data;

    // meter state mirrored from the block
    logic [DECAY_W-1:0] decay_q16;
    logic [63:0] held_peak [PLANES];
    logic [63:0] blk_peak [PLANES];
    logic [63:0] sq_sum [PLANES];
    int unsigned frames_in_block;
    logic [15:0] clips_seen;

    t_out_item pending_results[$];
    int unsigned mismatches;
    int unsigned cycles;
    bit          in_bias;

    // directed requests: sample values, end flag
    typedef struct {
        int s0, s1, s2, s3;
        bit eob;
    } t_row;
    t_row dir_rows[$];

    audio_block_peak_rms_meter uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // integer square root, bit by bit
    function automatic logic [63:0] int_sqrt(input logic [63:0] m);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > m) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (m >= res + bitv) begin
                m   = m - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] meter_scale(input logic [63:0] v);
        logic [63:0] prod;
        if (v >= FS) return LVL_MAX;
        prod = (v * 64'd65535) >> FULLSCALE_BITS;
        return prod[15:0];
    endfunction

    // advance the mirror by one frame and queue the results it causes
    task automatic predict_frame(input t_in_item it);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic [63:0] mag, sq, held, rms, frames;
        logic [OUT_W-1:0] outs [4];
        t_out_item r;
        bit closing;
        for (int p = 0; p < PLANES; p++) begin
            case (p)
                0: x = it.sample_0;
                1: x = it.sample_1;
                2: x = it.sample_2;
                default: x = it.sample_3;
            endcase
            mag = (x < 0) ? -x : x;
            sq  = mag * mag;
            if (mag > blk_peak[p]) blk_peak[p] = mag;
            if (sq_sum[p] > SUM_MAX - sq) sq_sum[p] = SUM_MAX;
            else sq_sum[p] = sq_sum[p] + sq;
            y = x;
            if (x >= FS) begin
                y = FS - 1;
                clips_seen++;
            end else if (x <= -FS) begin
                y = -FS;
                clips_seen++;
            end
            outs[p] = y[OUT_W-1:0];
        end
        frames_in_block++;
        closing = it.end_of_block || frames_in_block >= BLOCK_FRAMES;
        r = '0;
        r.kind = KIND_FRAME;
        r.out_0 = outs[0];
        r.out_1 = outs[1];
        r.out_2 = outs[2];
        r.out_3 = outs[3];
        r.clip_count = clips_seen;
        r.last = !closing;
        pending_results.push_back(r);
        if (closing) begin
            frames = frames_in_block;
            for (int p = 0; p < PLANES; p++) begin
                held = (held_peak[p] * decay_q16) >> 16;
                rms  = int_sqrt(sq_sum[p] / frames);
                if (blk_peak[p] > held) held = blk_peak[p];
                held_peak[p] = held & 64'hFFFFFFF;
                r = '0;
                r.kind = KIND_METER;
                r.plane = p[1:0];
                r.peak_level = meter_scale(held_peak[p]);
                r.rms_level  = meter_scale(rms);
                r.clip_count = clips_seen;
                r.last = (p == PLANES - 1);
                pending_results.push_back(r);
                blk_peak[p] = 0;
                sq_sum[p]   = 0;
            end
            frames_in_block = 0;
        end
    endtask

    // drive one request and hold it until taken
    task automatic send_frame(input t_in_item it);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_frame(it);
    endtask

    // drop valid for a random number of cycles, or keep going straight away
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
        if (in_bias) n = 0;
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_decay(input logic [DECAY_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        decay_q16 = v;
    endtask

    function automatic int rand_sample();
        int unsigned k;
        k = $urandom_range(0, 9);
        case (k)
            0: return $signed($urandom()) >>> 4;          // anywhere in 28 bits
            1: return FS + $urandom_range(0, 3);
            2: return -FS - $urandom_range(0, 3);
            3: return 0;
            default: return $signed($urandom_range(0, 2 * FS - 1)) - FS;
        endcase
    endfunction

    task automatic send_rand_block(input int len);
        t_in_item it;
        for (int k = 0; k < len; k++) begin
            it.sample_0 = SMP_W'(rand_sample());
            it.sample_1 = SMP_W'(rand_sample());
            it.sample_2 = SMP_W'(rand_sample());
            it.sample_3 = SMP_W'(rand_sample());
            it.end_of_block = (k == len - 1);
            send_frame(it);
            idle_gap();
        end
    endtask

    // check each result against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_out_data);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h got %h", want, o_out_data);
                end
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_out_ready <= ($urandom_range(0, 15) == 0) ? 1'b1 : ~i_out_ready;
        end else if (!i_out_ready && $urandom_range(0, 1) == 0) begin
            i_out_ready <= 1'b1;
        end
    end

    // timeout
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_in_item it;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        decay_q16  = DECAY_RESET;
        for (int p = 0; p < PLANES; p++) begin
            held_peak[p] = 0;
            blk_peak[p]  = 0;
            sq_sum[p]    = 0;
        end
        frames_in_block = 0;
        clips_seen = 0;
        mismatches = 0;
        cycles = 0;
        in_bias = 0;

        // extremes, clamps both ways, zero and a short block
        dir_rows.push_back('{0, 0, 0, 0, 1'b0});
        dir_rows.push_back('{FS - 1, -FS + 1, FS, -FS, 1'b0});
        dir_rows.push_back('{134217727, -134217728, 1, -1, 1'b0});
        dir_rows.push_back('{-134217728, 134217727, FS + 1, -FS - 1, 1'b1});
        dir_rows.push_back('{FS / 2, -FS / 2, 12345, -54321, 1'b1});
        dir_rows.push_back('{0, 0, 0, 0, 1'b1});
        dir_rows.push_back('{-1, 1, -FS, FS - 1, 1'b1});
        dir_rows.push_back('{FS * 15 + 777, -FS * 15, 3, 0, 1'b0});
        dir_rows.push_back('{5, -5, 5, -5, 1'b1});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            it.sample_0 = SMP_W'(dir_rows[k].s0);
            it.sample_1 = SMP_W'(dir_rows[k].s1);
            it.sample_2 = SMP_W'(dir_rows[k].s2);
            it.sample_3 = SMP_W'(dir_rows[k].s3);
            it.end_of_block = dir_rows[k].eob;
            send_frame(it);
            idle_gap();
        end
        // sender holds off until every meter report is back
        drain_and_settle();

        // extreme and mid decay settings
        write_decay(16'd0);
        send_rand_block(3);
        send_rand_block(1);
        drain_and_settle();
        write_decay(16'hFFFF);
        send_rand_block(2);
        send_rand_block(1);
        in_bias = 1;
        // a full block that closes on the frame count
        it = '0;
        for (int k = 0; k < BLOCK_FRAMES; k++) begin
            it.sample_0 = SMP_W'(rand_sample());
            it.sample_1 = SMP_W'(rand_sample());
            it.sample_2 = SMP_W'(rand_sample());
            it.sample_3 = SMP_W'(rand_sample());
            it.end_of_block = 1'b0;
            send_frame(it);
        end
        in_bias = 0;
        drain_and_settle();
        write_decay(DECAY_W'($urandom()));
        repeat (12) send_rand_block($urandom_range(1, 4));
        drain_and_settle();
        write_decay(DECAY_RESET);

        drain_and_settle();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/abprm_pkg.sv
rtl/abprm_lane.sv
rtl/audio_block_peak_rms_meter.sv
dv/audio_block_peak_rms_meter_test.sv
